/* rtl/lca_pkg.sv */
// ----------------------------------------------------------------------------
// Life cell automaton package
// Shared types, constants and rule functions of the B3/S23 stream engine.
// ----------------------------------------------------------------------------
package lca_pkg;

  localparam int ColsW      = 6;
  localparam int RowsW      = 11;
  localparam int ApbAddrW   = 3;
  localparam int ApbDataW   = 32;
  localparam int MaxColsDef = 32;
  localparam int MaxRowsDef = 1024;
  localparam int MinSize    = 3;
  localparam int BirthCount = 3;
  localparam int StayCount  = 2;

  localparam logic [ColsW-1:0] ColsReset = ColsW'(20);
  localparam logic [RowsW-1:0] RowsReset = RowsW'(20);

  typedef enum logic [0:0] {
    RegActiveCols = 1'b0,
    RegActiveRows = 1'b1
  } lca_reg_e;

  typedef struct packed {
    logic [ColsW-1:0] active_cols;
    logic [RowsW-1:0] active_rows;
  } lca_cfg_t;

  typedef struct packed {
    logic upper;
    logic middle;
  } lca_pair_t;

  typedef struct packed {
    logic write;
    logic load;
    logic shift;
  } lca_cell_ctrl_t;

  typedef struct packed {
    logic alive_next;
    logic frame_last;
  } lca_res_t;

  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    return (count == 4'(BirthCount)) || (alive && (count == 4'(StayCount)));
  endfunction

  // Rows of three bits: upper in [2:0], middle in [5:3], lower in [8:6].
  // Within a row, the lowest bit is the newest column.
  function automatic logic [8:0] win_shift(input logic [8:0] w, input logic u,
                                           input logic m, input logic l);
    return {w[7:6], l, w[4:3], m, w[1:0], u};
  endfunction

  function automatic logic win_result(input logic [8:0] w);
    logic [3:0] count;
    count = 4'(w[0]) + 4'(w[1]) + 4'(w[2]) + 4'(w[3])
          + 4'(w[5]) + 4'(w[6]) + 4'(w[7]) + 4'(w[8]);
    return life_rule(w[4], count);
  endfunction

endpackage

/* rtl/lca_in_if.sv */
// ----------------------------------------------------------------------------
// Life cell automaton input channel
// Valid/ready channel carrying one current-generation cell per transaction.
// ----------------------------------------------------------------------------
interface lca_in_if;
  logic valid;
  logic ready;
  logic alive_in;

  modport source (output valid, output alive_in, input ready);
  modport sink   (input valid, input alive_in, output ready);
endinterface

/* rtl/lca_out_if.sv */
// ----------------------------------------------------------------------------
// Life cell automaton output channel
// Valid/ready channel carrying one next-generation cell per transaction.
// ----------------------------------------------------------------------------
interface lca_out_if;
  logic valid;
  logic ready;
  logic alive_next;
  logic frame_last;

  modport source (output valid, output alive_next, output frame_last, input ready);
  modport sink   (input valid, input alive_next, input frame_last, output ready);
endinterface

/* rtl/life_cell_automaton_step_unit.sv */
// ----------------------------------------------------------------------------
// Life cell automaton step unit
// Streams the next B3/S23 generation of a grid given in raster order.
//
// The grid enters on cell_in_i, one cell per transaction, row by row.
// Results leave on cell_out_o in raster order; frame_last marks the final
// cell of each frame. The APB port sets active_cols and active_rows.
// A cell can be accepted in every cycle. The result of cell (r-1, c-1) is
// loaded into the output register at the edge that accepts cell (r, c) and
// is offered in the next cycle. The last cell of a row yields a second
// result, sent in the next cycle while the following cell is taken. The last
// cell of a frame copies the two row buffers into the flush chain of column
// cells, which then shifts out the whole last row one column at a time,
// after that second result; the first row of the next frame is taken
// meanwhile, since it yields no results. Output rate is one result a cycle,
// set by the single output register.
// Reset clears the row buffers, the window and the position, and sets both
// sizes to 20. When the receiver stalls, results collect in the output
// register and its skid entry, after which cells that yield results wait.
// ----------------------------------------------------------------------------
module life_cell_automaton_step_unit #(
  parameter int MAX_COLS = lca_pkg::MaxColsDef,
  parameter int MAX_ROWS = lca_pkg::MaxRowsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lca_in_if.sink                       cell_in_i,
  lca_out_if.source                    cell_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lca_pkg::ApbAddrW-1:0] paddr,
  input  logic [lca_pkg::ApbDataW-1:0] pwdata,
  output logic [lca_pkg::ApbDataW-1:0] prdata,
  output logic                         pready
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  lca_pkg::lca_cfg_t      cfg;
  lca_pkg::lca_cell_ctrl_t cell_ctrl;
  lca_pkg::lca_pair_t     store_pairs [MAX_COLS];
  lca_pkg::lca_pair_t     flush_pairs [MAX_COLS];
  lca_pkg::lca_pair_t     nbr_pairs   [MAX_COLS];
  lca_pkg::lca_pair_t     prev_q, prev_d, flush_next;
  lca_pkg::lca_res_t      gen_res, flush_res;

  logic [MAX_COLS-1:0] upper_vec, middle_vec, cell_sel;
  logic [CW-1:0]       col_last, col_pos_q, col_pos_d, c_eff, flush_cnt_q, flush_cnt_d;
  logic [RW-1:0]       row_last, row_pos_q, row_pos_d, r_eff;
  logic [8:0]          win_q, win_d, win_eff, win_base, win_a, win_b;
  logic [3:0]          flush_count;
  logic                restart, silent, in_accept, cur, u_rd, m_rd;
  logic                at_last_col, frame_end, res_a, res_b;
  logic                pend_b_q, pend_b_d, pend_alive_q;
  logic                flush_q, flush_d, flush_step, flush_end, pend_push;
  logic                can_push, gen_push;

  lca_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    if (32'(cfg.active_cols) < lca_pkg::MinSize) begin
      col_last = CW'(lca_pkg::MinSize - 1);
    end else if (32'(cfg.active_cols) > MAX_COLS) begin
      col_last = CW'(MAX_COLS - 1);
    end else begin
      col_last = CW'(cfg.active_cols - 1);
    end
    if (32'(cfg.active_rows) < lca_pkg::MinSize) begin
      row_last = RW'(lca_pkg::MinSize - 1);
    end else if (32'(cfg.active_rows) > MAX_ROWS) begin
      row_last = RW'(MAX_ROWS - 1);
    end else begin
      row_last = RW'(cfg.active_rows - 1);
    end
  end

  assign restart = (col_pos_q > col_last) || (row_pos_q > row_last);
  assign c_eff   = restart ? '0 : col_pos_q;
  assign r_eff   = restart ? '0 : row_pos_q;
  assign win_eff = restart ? '0 : win_q;

  assign silent      = (c_eff == '0) || (r_eff == '0);
  assign at_last_col = (c_eff == col_last);
  assign frame_end   = at_last_col && (r_eff == row_last);

  assign cell_in_i.ready = silent || (can_push && !pend_b_q && !flush_q);
  assign in_accept       = cell_in_i.valid && cell_in_i.ready;
  assign cur             = cell_in_i.alive_in;

  assign u_rd     = (r_eff[RW-1:1] != '0) ? upper_vec[c_eff] : 1'b0;
  assign m_rd     = (r_eff != '0) ? middle_vec[c_eff] : 1'b0;
  assign win_base = (c_eff == '0) ? '0 : win_eff;
  assign win_a    = lca_pkg::win_shift(win_base, u_rd, m_rd, cur);
  assign win_b    = lca_pkg::win_shift(win_a, 1'b0, 1'b0, 1'b0);
  assign res_a    = lca_pkg::win_result(win_a);
  assign res_b    = lca_pkg::win_result(win_b);

  always_comb begin
    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    win_d     = win_q;
    if (in_accept) begin
      if (frame_end) begin
        col_pos_d = '0;
        row_pos_d = '0;
        win_d     = '0;
      end else if (at_last_col) begin
        col_pos_d = '0;
        row_pos_d = r_eff + RW'(1);
        win_d     = win_b;
      end else begin
        col_pos_d = c_eff + CW'(1);
        row_pos_d = r_eff;
        win_d     = win_a;
      end
    end
  end

  assign cell_ctrl.write = in_accept;
  assign cell_ctrl.load  = in_accept && frame_end;
  assign cell_ctrl.shift = flush_step;

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    if (k == MAX_COLS - 1) begin : g_tail
      assign nbr_pairs[k] = '0;
    end else begin : g_link
      assign nbr_pairs[k] = flush_pairs[k+1];
    end

    assign cell_sel[k]   = (c_eff == CW'(k));
    assign upper_vec[k]  = store_pairs[k].upper;
    assign middle_vec[k] = store_pairs[k].middle;

    lca_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .sel_i   (cell_sel[k]),
      .cur_i   (cur),
      .nbr_i   (nbr_pairs[k]),
      .store_o (store_pairs[k]),
      .flush_o (flush_pairs[k])
    );
  end

  assign pend_push  = pend_b_q && can_push;
  assign flush_step = flush_q && !pend_b_q && can_push;
  assign flush_end  = (flush_cnt_q == col_last);
  assign flush_next = flush_end ? '0 : flush_pairs[1];

  assign flush_count = 4'(prev_q.upper) + 4'(prev_q.middle) + 4'(flush_pairs[0].upper)
                     + 4'(flush_next.upper) + 4'(flush_next.middle);
  assign flush_res.alive_next = lca_pkg::life_rule(flush_pairs[0].middle, flush_count);
  assign flush_res.frame_last = flush_end;

  always_comb begin
    pend_b_d    = pend_b_q;
    flush_d     = flush_q;
    flush_cnt_d = flush_cnt_q;
    prev_d      = prev_q;
    if (in_accept && !silent && at_last_col) begin
      pend_b_d = 1'b1;
    end else if (pend_push) begin
      pend_b_d = 1'b0;
    end
    if (cell_ctrl.load) begin
      flush_d     = 1'b1;
      flush_cnt_d = '0;
      prev_d      = '0;
    end else if (flush_step) begin
      flush_d     = !flush_end;
      flush_cnt_d = flush_cnt_q + CW'(1);
      prev_d      = flush_pairs[0];
    end
  end

  always_comb begin
    if (pend_b_q) begin
      gen_res.alive_next = pend_alive_q;
      gen_res.frame_last = 1'b0;
    end else if (flush_q) begin
      gen_res = flush_res;
    end else begin
      gen_res.alive_next = res_a;
      gen_res.frame_last = 1'b0;
    end
  end

  assign gen_push = pend_push || flush_step || (in_accept && !silent);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      win_q       <= '0;
      pend_b_q    <= 1'b0;
      flush_q     <= 1'b0;
      flush_cnt_q <= '0;
      prev_q      <= '0;
    end else begin
      col_pos_q   <= col_pos_d;
      row_pos_q   <= row_pos_d;
      win_q       <= win_d;
      pend_b_q    <= pend_b_d;
      flush_q     <= flush_d;
      flush_cnt_q <= flush_cnt_d;
      prev_q      <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && !silent && at_last_col) begin
      pend_alive_q <= res_b;
    end
  end

  lca_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (gen_push),
    .res_i      (gen_res),
    .can_push_o (can_push),
    .out_o      (cell_out_o)
  );

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !silent |-> can_push && !pend_b_q && !flush_q)
    else $error("cell with a result accepted while the result slot is taken");

  a_frame_end_starts_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && frame_end |=> flush_q && pend_b_q)
    else $error("final cell of a frame did not start the flush");

  a_last_only_from_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_push && gen_res.frame_last |-> flush_step)
    else $error("frame end mark outside the flush of the last row");

  a_flush_count_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> flush_cnt_q <= col_last)
    else $error("flush counter ran past the last column");

endmodule

/* rtl/lca_cfg.sv */
// ----------------------------------------------------------------------------
// Life cell automaton configuration registers
// APB-style register file holding the active grid width and height.
// ----------------------------------------------------------------------------
module lca_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lca_pkg::ApbAddrW-1:0] paddr,
  input  logic [lca_pkg::ApbDataW-1:0] pwdata,
  output logic [lca_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output lca_pkg::lca_cfg_t            cfg_o
);

  logic [lca_pkg::ColsW-1:0] cols_q;
  logic [lca_pkg::RowsW-1:0] rows_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= lca_pkg::ColsReset;
      rows_q <= lca_pkg::RowsReset;
    end else if (wr_en) begin
      case (paddr[2])
        lca_pkg::RegActiveCols: cols_q <= pwdata[lca_pkg::ColsW-1:0];
        lca_pkg::RegActiveRows: rows_q <= pwdata[lca_pkg::RowsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lca_pkg::RegActiveCols: prdata = lca_pkg::ApbDataW'(cols_q);
      lca_pkg::RegActiveRows: prdata = lca_pkg::ApbDataW'(rows_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.active_cols = cols_q;
  assign cfg_o.active_rows = rows_q;

endmodule

/* rtl/lca_cell.sv */
// ----------------------------------------------------------------------------
// Life cell automaton column cell
// Holds the two row-buffer bits of one column and a flush copy of them that
// moves one cell toward column zero on every flush step.
// ----------------------------------------------------------------------------
module lca_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lca_pkg::lca_cell_ctrl_t ctrl_i,
  input  logic                    sel_i,
  input  logic                    cur_i,
  input  lca_pkg::lca_pair_t      nbr_i,
  output lca_pkg::lca_pair_t      store_o,
  output lca_pkg::lca_pair_t      flush_o
);

  lca_pkg::lca_pair_t store_q, store_d;
  lca_pkg::lca_pair_t flush_q, flush_d;

  always_comb begin
    store_d = store_q;
    if (ctrl_i.write && sel_i) begin
      store_d.upper  = store_q.middle;
      store_d.middle = cur_i;
    end
    flush_d = flush_q;
    if (ctrl_i.load) begin
      flush_d = store_d;
    end else if (ctrl_i.shift) begin
      flush_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      flush_q <= '0;
    end else begin
      store_q <= store_d;
      flush_q <= flush_d;
    end
  end

  assign store_o = store_q;
  assign flush_o = flush_q;

endmodule

/* rtl/lca_out_buf.sv */
// ----------------------------------------------------------------------------
// Life cell automaton output buffer
// Output register with a skid entry; the producer waits only while the skid entry is full.
// ----------------------------------------------------------------------------
module lca_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lca_pkg::lca_res_t res_i,
  output logic              can_push_o,
  lca_out_if.source         out_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  lca_pkg::lca_res_t out_res_q, out_res_d;
  lca_pkg::lca_res_t skid_res_q;
  logic              load_out, load_skid, pop;

  assign pop = out_valid_q & out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        load_out     = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
    out_res_d = skid_valid_q ? skid_res_q : res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_res_q <= out_res_d;
    end
    if (load_skid) begin
      skid_res_q <= res_i;
    end
  end

  assign can_push_o       = ~skid_valid_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.alive_next = out_res_q.alive_next;
  assign out_o.frame_last = out_res_q.frame_last;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Life cell automaton step unit testbench
// Streams random and hand-picked grids into the block and checks every
// next-generation cell it sends back against a B3/S23 predictor kept in a
// small scoreboard class. The grid size is changed between transactions
// through the APB port, at frame ends, in mid frame, and out of range.
// Both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int MaxCols      = lca_pkg::MaxColsDef;
  localparam int MaxRows      = lca_pkg::MaxRowsDef;
  localparam int TallRows     = 12;
  localparam int RandomCells  = 200;
  localparam int SettleCycles = 48;
  localparam int ReportLimit  = 10;
  localparam int TimeLimitNs  = 2_000_000;

  class life_scoreboard;
    bit upper_row [MaxCols];
    bit middle_row [MaxCols];
    bit [2:0] win_up;
    bit [2:0] win_mid;
    bit [2:0] win_low;
    int unsigned col_pos;
    int unsigned row_pos;
    logic [lca_pkg::ColsW-1:0] cols_reg;
    logic [lca_pkg::RowsW-1:0] rows_reg;
    lca_pkg::lca_res_t next_gen_cells[$];
    int unsigned cells_taken;
    int unsigned results_checked;
    int unsigned frames_closed;
    int unsigned errors;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = 1'b0;
        middle_row[i] = 1'b0;
      end
      clear_window();
      col_pos         = 0;
      row_pos         = 0;
      cols_reg        = lca_pkg::ColsReset;
      rows_reg        = lca_pkg::RowsReset;
      cells_taken     = 0;
      results_checked = 0;
      frames_closed   = 0;
      errors          = 0;
    endfunction

    function void set_reg(lca_pkg::lca_reg_e idx, logic [lca_pkg::ApbDataW-1:0] value);
      case (idx)
        lca_pkg::RegActiveCols: cols_reg = value[lca_pkg::ColsW-1:0];
        lca_pkg::RegActiveRows: rows_reg = value[lca_pkg::RowsW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned used_cols();
      if (cols_reg < lca_pkg::MinSize) return lca_pkg::MinSize;
      if (cols_reg > MaxCols) return MaxCols;
      return cols_reg;
    endfunction

    function int unsigned used_rows();
      if (rows_reg < lca_pkg::MinSize) return lca_pkg::MinSize;
      if (rows_reg > MaxRows) return MaxRows;
      return rows_reg;
    endfunction

    function int unsigned frame_cells();
      return used_cols() * used_rows();
    endfunction

    function void clear_window();
      win_up  = '0;
      win_mid = '0;
      win_low = '0;
    endfunction

    function void shift_window(bit u, bit m, bit l);
      win_up  = {win_up[1:0], u};
      win_mid = {win_mid[1:0], m};
      win_low = {win_low[1:0], l};
    endfunction

    function bit next_state(bit alive, int unsigned neighbours);
      return (neighbours == lca_pkg::BirthCount)
          || (alive && neighbours == lca_pkg::StayCount);
    endfunction

    function bit window_next_state();
      return next_state(win_mid[1], $countones({win_up, win_low, win_mid[2], win_mid[0]}));
    endfunction

    function void expect_cell(bit alive_next, bit frame_last);
      lca_pkg::lca_res_t res;
      res.alive_next = alive_next;
      res.frame_last = frame_last;
      next_gen_cells.push_back(res);
    endfunction

    function void predict_next_gen(bit alive);
      int unsigned ncols;
      int unsigned nrows;
      int unsigned c;
      int unsigned r;
      int unsigned neighbours;
      int col;
      bit u;
      bit m;

      ncols = used_cols();
      nrows = used_rows();
      cells_taken++;
      if (col_pos >= ncols || row_pos >= nrows) begin
        col_pos = 0;
        row_pos = 0;
        clear_window();
      end
      c = col_pos;
      r = row_pos;
      u = (r >= 2) ? upper_row[c] : 1'b0;
      m = (r >= 1) ? middle_row[c] : 1'b0;
      upper_row[c]  = middle_row[c];
      middle_row[c] = alive;
      if (c == 0) clear_window();
      shift_window(u, m, alive);

      if (r >= 1) begin
        if (c >= 1) expect_cell(window_next_state(), 1'b0);
        if (c == ncols - 1) begin
          shift_window(1'b0, 1'b0, 1'b0);
          expect_cell(window_next_state(), 1'b0);
        end
      end

      if (c == ncols - 1 && r == nrows - 1) begin
        for (int k = 0; k < ncols; k++) begin
          neighbours = 0;
          for (int j = -1; j <= 1; j++) begin
            col = k + j;
            if (col >= 0 && col < ncols) begin
              neighbours += upper_row[col];
              if (j != 0) neighbours += middle_row[col];
            end
          end
          expect_cell(next_state(middle_row[k], neighbours), k == ncols - 1);
        end
        col_pos = 0;
        row_pos = 0;
        clear_window();
      end else begin
        col_pos = c + 1;
        if (col_pos >= ncols) begin
          col_pos = 0;
          row_pos = r + 1;
        end
      end
    endfunction

    function void check_next_gen(logic alive_next, logic frame_last);
      lca_pkg::lca_res_t want;
      results_checked++;
      if (frame_last === 1'b1) frames_closed++;
      if (next_gen_cells.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("Result %0d came with none expected: alive %b, last %b",
                   results_checked, alive_next, frame_last);
        return;
      end
      want = next_gen_cells.pop_front();
      if (alive_next !== want.alive_next || frame_last !== want.frame_last) begin
        errors++;
        if (errors <= ReportLimit)
          $display("Result %0d: expected alive %b last %b, got alive %b last %b",
                   results_checked, want.alive_next, want.frame_last,
                   alive_next, frame_last);
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lca_pkg::ApbAddrW-1:0] paddr;
  logic [lca_pkg::ApbDataW-1:0] pwdata;
  logic [lca_pkg::ApbDataW-1:0] prdata;
  logic                         pready;
  bit                           no_idle;
  int unsigned                  setups;
  life_scoreboard               sb;

  lca_in_if  cell_in();
  lca_out_if cell_out();

  life_cell_automaton_step_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_in_i  (cell_in),
    .cell_out_o (cell_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && cell_out.valid === 1'b1 && cell_out.ready === 1'b1)
      sb.check_next_gen(cell_out.alive_next, cell_out.frame_last);
  end

  initial begin
    cell_out.ready <= 1'b1;
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        cell_out.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      cell_out.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    #(TimeLimitNs);
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input lca_pkg::lca_reg_e idx,
                           input logic [lca_pkg::ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    setups++;
    @(posedge clk_i);
  endtask

  task automatic send_cell(input bit alive);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      cell_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    cell_in.valid    <= 1'b1;
    cell_in.alive_in <= alive;
    do @(posedge clk_i); while (cell_in.ready !== 1'b1);
    sb.predict_next_gen(alive);
  endtask

  task automatic feed_cells(input int unsigned count, input int unsigned pct);
    for (int unsigned i = 0; i < count; i++)
      send_cell($urandom_range(0, 99) < pct);
  endtask

  task automatic feed_bits(input logic [31:0] bits, input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_cell(bits[i]);
  endtask

  task automatic drain_results();
    cell_in.valid <= 1'b0;
    while (sb.next_gen_cells.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [lca_pkg::ApbDataW-1:0] pick_cols();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, lca_pkg::MinSize - 1);
      1:       return MaxCols;
      2:       return $urandom_range(MaxCols + 1, (1 << lca_pkg::ColsW) - 1);
      3:       return lca_pkg::MinSize;
      default: return $urandom_range(lca_pkg::MinSize, 8);
    endcase
  endfunction

  function automatic logic [lca_pkg::ApbDataW-1:0] pick_rows();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, lca_pkg::MinSize - 1);
      1:       return lca_pkg::MinSize;
      default: return $urandom_range(lca_pkg::MinSize, 6);
    endcase
  endfunction

  function automatic int unsigned pick_density();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 100;
      default: return $urandom_range(15, 60);
    endcase
  endfunction

  initial begin
    int unsigned first_random;
    int unsigned frame_len;
    int unsigned pct;

    sb               = new();
    setups           = 0;
    no_idle          = 1'b0;
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    cell_in.valid    <= 1'b0;
    cell_in.alive_in <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A partial frame at the reset size, then a shrink that restarts the frame.
    feed_bits(32'h0049_2C5B, 23);
    drain_results();
    write_reg(lca_pkg::RegActiveCols, lca_pkg::MinSize);
    write_reg(lca_pkg::RegActiveRows, lca_pkg::MinSize);
    feed_bits('1, 9);
    drain_results();

    write_reg(lca_pkg::RegActiveRows, TallRows);
    feed_cells(lca_pkg::MinSize * TallRows, 35);
    drain_results();
    write_reg(lca_pkg::RegActiveCols, (1 << lca_pkg::ColsW) - 1);
    write_reg(lca_pkg::RegActiveRows, (1 << lca_pkg::RowsW) - 1);
    feed_cells(100, 50);
    drain_results();
    write_reg(lca_pkg::RegActiveCols, 4);
    feed_cells(40, 50);
    drain_results();
    write_reg(lca_pkg::RegActiveCols, 0);
    write_reg(lca_pkg::RegActiveRows, 0);
    feed_cells(9, 60);
    drain_results();

    first_random = sb.cells_taken;
    while (sb.cells_taken - first_random < RandomCells) begin
      if (sb.cells_taken - first_random > RandomCells * 3 / 4) no_idle = 1'b1;
      write_reg(lca_pkg::RegActiveCols, pick_cols());
      if ($urandom_range(0, 1) == 1) write_reg(lca_pkg::RegActiveRows, pick_rows());
      pct       = pick_density();
      frame_len = sb.frame_cells();
      if ($urandom_range(0, 9) < 7) begin
        feed_cells(frame_len * $urandom_range(1, 2), pct);
      end else begin
        feed_cells($urandom_range(1, frame_len - 1), pct);
        drain_results();
        write_reg(lca_pkg::RegActiveCols, pick_cols());
        if ($urandom_range(0, 1) == 1) write_reg(lca_pkg::RegActiveRows, pick_rows());
        feed_cells($urandom_range(1, 2 * sb.frame_cells()), pct);
      end
      drain_results();
    end

    if (sb.next_gen_cells.size() != 0) begin
      $display("%0d expected results never arrived", sb.next_gen_cells.size());
      sb.errors += sb.next_gen_cells.size();
    end
    $display("Fed %0d cells over %0d register writes, with full, partial and resized frames.",
             sb.cells_taken, setups);
    $display("Checked %0d results in %0d closed frames, %0d mismatches.",
             sb.results_checked, sb.frames_closed, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
